// File: hw/rtl/skf_pkg.sv
`default_nettype none

package skf_pkg;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_ESTIMATE  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_COVARIANCE = 2'd3;

    typedef struct packed {
        logic load;
        logic pred;
        logic sum;
        logic div;
        logic div_last;
        logic mul;
        logic est;
        logic fin;
    } skf_ctrl_t;

endpackage

`default_nettype wire

// File: hw/rtl/skf_ctrl.sv
`default_nettype none

module skf_ctrl
    import skf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      start,
    input  wire logic      out_free,
    output logic           ready,
    output skf_ctrl_t      ctrl
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] DivLast = CNT_W'(FRAC_BITS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PRED = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_EST  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_PRED;
                end
            end
            ST_PRED: state_next = ST_SUM;
            ST_SUM: begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV: begin
                if (cnt_reg == DivLast) begin
                    state_next = ST_MUL;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MUL: state_next = ST_EST;
            ST_EST: state_next = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        ready         = (state_reg == ST_IDLE);
        ctrl.load     = ready && start;
        ctrl.pred     = (state_reg == ST_PRED);
        ctrl.sum      = (state_reg == ST_SUM);
        ctrl.div      = (state_reg == ST_DIV);
        ctrl.div_last = (state_reg == ST_DIV) && (cnt_reg == DivLast);
        ctrl.mul      = (state_reg == ST_MUL);
        ctrl.est      = (state_reg == ST_EST);
        ctrl.fin      = (state_reg == ST_FIN) && out_free;
    end

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && start) |=> (state_reg == ST_PRED))
        else $error("accepted word did not start the predict step");

    a_div_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && cnt_reg == DivLast) |=> (state_reg == ST_MUL))
        else $error("division did not end after its last quotient bit");

    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (cnt_reg <= DivLast))
        else $error("division counter ran past its last bit");

endmodule

`default_nettype wire

// File: hw/rtl/skf_dpath.sv
`default_nettype none

module skf_dpath
    import skf_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire skf_ctrl_t                    ctrl,
    input  wire logic signed [DATA_WIDTH-1:0] meas_in,
    input  wire logic                         restart_in,
    input  wire logic [DATA_WIDTH-1:0]        q_in,
    input  wire logic [DATA_WIDTH-1:0]        r_in,
    input  wire logic signed [DATA_WIDTH-1:0] init_est_in,
    input  wire logic [DATA_WIDTH-1:0]        init_cov_in,
    output logic signed [DATA_WIDTH-1:0]      est_out,
    output logic [FRAC_BITS:0]                gain_out,
    output logic [DATA_WIDTH-1:0]             cov_out
);

    localparam int DW = DATA_WIDTH;
    localparam int PW = DATA_WIDTH + FRAC_BITS + 4;
    localparam logic [FRAC_BITS:0] OneFx = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic [DATA_WIDTH-1:0] CovOne = DATA_WIDTH'(1) << FRAC_BITS;
    localparam logic signed [DATA_WIDTH+1:0] EstMax = {3'b000, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH+1:0] EstMin = {3'b111, {(DATA_WIDTH-1){1'b0}}};

    logic signed [DW-1:0]   meas_reg;
    logic signed [DW-1:0]   est_reg;
    logic [DW-1:0]          cov_reg;
    logic [DW-1:0]          p_reg;
    logic signed [DW:0]     resid_reg;
    logic [DW:0]            sum_reg;
    logic                   zero_reg;
    logic [DW+1:0]          rem_reg;
    logic [FRAC_BITS:0]     k_reg;
    logic signed [PW-1:0]   prod_reg;

    logic [DW:0]            pred_sum;
    logic [DW:0]            gain_den;
    logic [DW+2:0]          trial;
    logic                   qbit;
    logic [DW+1:0]          keep;
    logic signed [DW+1:0]   mul_a;
    logic signed [FRAC_BITS+1:0] mul_b;
    logic signed [PW-1:0]   prod_sh;
    logic signed [DW+1:0]   est_sum;
    logic signed [DW-1:0]   est_sat;
    logic [DW-1:0]          cov_new;

    always_comb begin
        pred_sum = {1'b0, cov_reg} + {1'b0, q_in};
        gain_den = {1'b0, p_reg} + {1'b0, r_in};
        trial    = {1'b0, rem_reg} - {2'b00, sum_reg};
        qbit     = ~trial[DW+2];
        keep     = qbit ? trial[DW+1:0] : rem_reg;
        if (ctrl.est) begin
            mul_a = $signed({2'b00, p_reg});
            mul_b = $signed({1'b0, OneFx - k_reg});
        end else begin
            mul_a = $signed({resid_reg[DW], resid_reg});
            mul_b = $signed({1'b0, k_reg});
        end
        prod_sh = prod_reg >>> FRAC_BITS;
        est_sum = $signed({{2{est_reg[DW-1]}}, est_reg}) + $signed(prod_sh[DW+1:0]);
        if (est_sum > EstMax) begin
            est_sat = EstMax[DW-1:0];
        end else if (est_sum < EstMin) begin
            est_sat = EstMin[DW-1:0];
        end else begin
            est_sat = est_sum[DW-1:0];
        end
        cov_new = prod_reg[FRAC_BITS +: DW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_reg <= '0;
            cov_reg <= CovOne;
        end else begin
            if (ctrl.load && restart_in) begin
                est_reg <= init_est_in;
                cov_reg <= init_cov_in;
            end
            if (ctrl.est) begin
                est_reg <= est_sat;
            end
            if (ctrl.fin) begin
                cov_reg <= cov_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            meas_reg <= meas_in;
        end
        if (ctrl.pred) begin
            p_reg     <= pred_sum[DW] ? {DW{1'b1}} : pred_sum[DW-1:0];
            resid_reg <= $signed({meas_reg[DW-1], meas_reg})
                       - $signed({est_reg[DW-1], est_reg});
        end
        if (ctrl.sum) begin
            sum_reg  <= gain_den;
            zero_reg <= (gain_den == '0);
            rem_reg  <= {2'b00, p_reg};
            k_reg    <= '0;
        end
        if (ctrl.div) begin
            rem_reg <= {keep[DW:0], 1'b0};
            if (ctrl.div_last && zero_reg) begin
                k_reg <= '0;
            end else begin
                k_reg <= {k_reg[FRAC_BITS-1:0], qbit};
            end
        end
        if (ctrl.mul || ctrl.est) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    assign est_out  = est_reg;
    assign gain_out = k_reg;
    assign cov_out  = cov_new;

    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.mul |-> (k_reg <= OneFx))
        else $error("gain exceeds one");

    a_zero_gain: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.mul && zero_reg) |-> (k_reg == '0))
        else $error("gain is not zero for a zero denominator");

    a_cov_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.fin |-> (cov_new <= p_reg))
        else $error("updated covariance exceeds predicted covariance");

endmodule

`default_nettype wire

// File: hw/rtl/scalar_kalman_filter.sv
// Scalar Kalman filter on a stream of signed fixed-point measurements.
// The input channel (s_*) carries one measurement per word in s_tdata and a
// restart flag in s_tuser; a set flag reloads the estimate and covariance
// from the initial registers before the word is processed.
// The result channel (m_*) carries the new estimate, the gain used and the
// new covariance for every input word, in input order.
// Registers are written through the cfg_* channel, which is always ready;
// write them only while no word is in flight.
// Each word passes through one sequencer: predict, sum, a restoring divider
// that produces one gain bit per cycle, then two passes through a single
// shared multiplier. A new word is taken only once the sequencer is back
// in idle, once the last result has gone into the output register.
// The result sits in an output register, so the next word is accepted while
// the receiver stalls; a second result waits inside the block until that
// register is free.
// Reset loads all configuration registers with their defaults and sets
// the estimate to zero and the covariance to one.
`default_nettype none

module scalar_kalman_filter
    import skf_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [((DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,   // measurement
    input  wire logic                   s_tuser,   // restart

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [((2 * DATA_WIDTH + FRAC_BITS + 1 + 7) / 8) * 8 - 1:0] m_tdata,
                                                   // estimate, gain, covariance

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [DATA_WIDTH-1:0]  cfg_data
);

    localparam int OutW = ((2 * DATA_WIDTH + FRAC_BITS + 1 + 7) / 8) * 8;
    localparam logic [DATA_WIDTH-1:0] CovOne  = DATA_WIDTH'(1) << FRAC_BITS;
    localparam logic [DATA_WIDTH-1:0] QReset  = DATA_WIDTH'((64'd1 << FRAC_BITS) / 100);

    logic [DATA_WIDTH-1:0]        q_reg;
    logic [DATA_WIDTH-1:0]        r_reg;
    logic signed [DATA_WIDTH-1:0] init_est_reg;
    logic [DATA_WIDTH-1:0]        init_cov_reg;

    skf_ctrl_t                    ctrl;
    logic                         out_free;
    logic signed [DATA_WIDTH-1:0] est_w;
    logic [FRAC_BITS:0]           gain_w;
    logic [DATA_WIDTH-1:0]        cov_w;

    logic                         out_valid_reg;
    logic [DATA_WIDTH-1:0]        est_o_reg;
    logic [FRAC_BITS:0]           gain_o_reg;
    logic [DATA_WIDTH-1:0]        cov_o_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg        <= QReset;
            r_reg        <= CovOne;
            init_est_reg <= '0;
            init_cov_reg <= CovOne;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_PROCESS_NOISE:      q_reg        <= cfg_data;
                REG_MEASUREMENT_NOISE:  r_reg        <= cfg_data;
                REG_INITIAL_ESTIMATE:   init_est_reg <= cfg_data;
                REG_INITIAL_COVARIANCE: init_cov_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_tready;

    skf_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_tvalid),
        .out_free (out_free),
        .ready    (s_tready),
        .ctrl     (ctrl)
    );

    skf_dpath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ctrl),
        .meas_in     (s_tdata[DATA_WIDTH-1:0]),
        .restart_in  (s_tuser),
        .q_in        (q_reg),
        .r_in        (r_reg),
        .init_est_in (init_est_reg),
        .init_cov_in (init_cov_reg),
        .est_out     (est_w),
        .gain_out    (gain_w),
        .cov_out     (cov_w)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.fin) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.fin) begin
            est_o_reg  <= est_w;
            gain_o_reg <= gain_w;
            cov_o_reg  <= cov_w;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OutW'({cov_o_reg, gain_o_reg, est_o_reg});

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import skf_pkg::*;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam int GW = FB + 1;
    localparam int IN_W = 32;
    localparam int OUT_W = 88;
    localparam int SETTLE_CYCLES = FB + 20;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT_CYCLES = 600000;
    localparam logic [63:0] ONE_FX = 64'd1 << FB;
    localparam logic [63:0] DMAX = (64'd1 << DW) - 1;
    localparam longint EST_MAX = (longint'(1) <<< (DW - 1)) - 1;
    localparam longint EST_MIN = -(longint'(1) <<< (DW - 1));
    localparam logic [DW-1:0] MEAS_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] MEAS_MIN = {1'b1, {(DW-1){1'b0}}};

    typedef struct packed {
        logic [DW-1:0] estimate;
        logic [GW-1:0] gain;
        logic [DW-1:0] covariance;
    } filter_update_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_W-1:0]       m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DW-1:0]          cfg_data = '0;

    // Filter registers and state as the block should hold them.
    logic [DW-1:0] q_noise;
    logic [DW-1:0] r_noise;
    logic [DW-1:0] init_est;
    logic [DW-1:0] init_cov;
    logic [DW-1:0] est_state;
    logic [DW-1:0] cov_state;

    filter_update_t pending_updates[$];

    int fail_count = 0;
    int cycle_count = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    scalar_kalman_filter #(
        .DATA_WIDTH(DW),
        .FRAC_BITS (FB)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // measurement
        .s_tuser  (s_tuser),   // restart
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // estimate, gain, covariance
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic filter_update_t filter_step(input logic [DW-1:0] meas,
                                                   input logic restart);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] k;
        logic [63:0] mag;
        longint resid;
        longint x;
        filter_update_t u;
        if (restart) begin
            est_state = init_est;
            cov_state = init_cov;
        end
        p = 64'(cov_state) + 64'(q_noise);
        if (p > DMAX) p = DMAX;
        sum = p + 64'(r_noise);
        k = (sum == 0) ? 64'd0 : (p << FB) / sum;
        if (k > ONE_FX) k = ONE_FX;
        x = longint'($signed(est_state));
        resid = longint'($signed(meas)) - x;
        // The product is floored, so a negative correction rounds away from zero.
        if (resid >= 0) begin
            mag = 64'(resid) * k;
            x = x + longint'(mag >> FB);
        end else begin
            mag = 64'(-resid) * k;
            x = x - longint'((mag + ONE_FX - 1) >> FB);
        end
        if (x > EST_MAX) x = EST_MAX;
        if (x < EST_MIN) x = EST_MIN;
        est_state = DW'(x);
        cov_state = DW'((p * (ONE_FX - k)) >> FB);
        u.estimate = est_state;
        u.gain = GW'(k);
        u.covariance = cov_state;
        return u;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want != got) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        filter_update_t want;
        filter_update_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.estimate = m_tdata[DW-1:0];
            got.gain = m_tdata[DW+GW-1:DW];
            got.covariance = m_tdata[2*DW+GW-1:DW+GW];
            if (pending_updates.size() == 0) begin
                $error("result word with no expected update: %0h", m_tdata);
                fail_count++;
            end else begin
                want = pending_updates.pop_front();
                check_field("estimate", 64'(want.estimate), 64'(got.estimate));
                check_field("gain", 64'(want.gain), 64'(got.gain));
                check_field("covariance", 64'(want.covariance), 64'(got.covariance));
            end
        end
    end

    // A hold-off request keeps the receiver stalled for a fixed stretch.
    always @(negedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic send_measurement(input logic [DW-1:0] meas, input logic restart);
        int gap;
        gap = ($urandom_range(0, 99) < send_gap_pct) ? $urandom_range(1, 30) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= meas;
        s_tuser <= restart;
        do @(posedge aclk); while (!s_tready);
        pending_updates.push_back(filter_step(meas, restart));
    endtask

    task automatic wait_until_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [DW-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_PROCESS_NOISE:      q_noise = val;
            REG_MEASUREMENT_NOISE:  r_noise = val;
            REG_INITIAL_ESTIMATE:   init_est = val;
            REG_INITIAL_COVARIANCE: init_cov = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_filter(input logic [DW-1:0] q, input logic [DW-1:0] r,
                              input logic [DW-1:0] est, input logic [DW-1:0] cov);
        wait_until_drained();
        write_reg(REG_PROCESS_NOISE, q);
        write_reg(REG_MEASUREMENT_NOISE, r);
        write_reg(REG_INITIAL_ESTIMATE, est);
        write_reg(REG_INITIAL_COVARIANCE, cov);
    endtask

    function automatic logic [DW-1:0] pick_noise();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return DMAX[DW-1:0];
            2, 3: return DW'($urandom_range(1, 1 << 12));
            4, 5: return DW'($urandom_range(1 << 12, 1 << 20));
            default: return DW'($urandom());
        endcase
    endfunction

    function automatic logic [DW-1:0] pick_estimate();
        case ($urandom_range(0, 5))
            0: return MEAS_MAX;
            1: return MEAS_MIN;
            2, 3: return DW'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
            default: return DW'($urandom());
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_measurement('0, 1'b0);
        send_measurement(MEAS_MAX, 1'b0);
        send_measurement(MEAS_MIN, 1'b0);
        send_measurement('1, 1'b1);
        send_measurement(DW'(ONE_FX), 1'b0);
    endtask

    task automatic test_zero_denominator();
        set_filter('0, '0, 32'h1234_5678, '0);
        send_measurement(MEAS_MIN, 1'b1);
        send_measurement(MEAS_MAX, 1'b0);
    endtask

    task automatic test_covariance_saturation();
        set_filter('1, '1, MEAS_MIN, '1);
        send_measurement(MEAS_MAX, 1'b1);
        send_measurement('0, 1'b0);
        send_measurement(MEAS_MIN, 1'b0);
    endtask

    task automatic test_unit_gain();
        set_filter(32'h0000_1000, '0, MEAS_MAX, DW'(ONE_FX));
        send_measurement(MEAS_MIN, 1'b1);
        send_measurement(MEAS_MAX, 1'b0);
        send_measurement('0, 1'b1);
    endtask

    task automatic test_floor_rounding();
        set_filter(32'd655, 32'h0003_0000, '0, DW'(ONE_FX));
        send_measurement('1, 1'b1);
        send_measurement(32'd1, 1'b0);
        send_measurement(32'hFFFF_0001, 1'b0);
        send_measurement(32'd3, 1'b0);
    endtask

    task automatic run_track(input int count);
        int track;
        int pick;
        logic [DW-1:0] meas;
        track = int'(pick_estimate());
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                track = track + int'($urandom_range(0, 2048)) - 1024;
                meas = DW'(track + int'($urandom_range(0, 1 << 18)) - (1 << 17));
            end else if (pick < 90) begin
                meas = DW'($urandom());
            end else if (pick < 95) begin
                meas = MEAS_MAX;
            end else begin
                meas = MEAS_MIN;
            end
            send_measurement(meas, (i == 0) || ($urandom_range(0, 99) < 4));
        end
    endtask

    task automatic test_backpressure();
        send_gap_pct = 0;
        recv_stall_pct = 0;
        set_filter(32'd655, 32'h0001_0000, '0, DW'(ONE_FX));
        hold_requests++;
        run_track(12);
        wait_until_drained();
        run_track(5);
        wait_until_drained();
        run_track(5);
    endtask

    task automatic test_random_phase(input int gap_pct, input int stall_pct);
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        for (int s = 0; s < 4; s++) begin
            set_filter(pick_noise(), pick_noise(), pick_estimate(), pick_noise());
            run_track(68);
        end
    endtask

    initial begin
        q_noise = 32'd655;
        r_noise = DW'(ONE_FX);
        init_est = '0;
        init_cov = DW'(ONE_FX);
        est_state = init_est;
        cov_state = init_cov;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_zero_denominator();
        test_covariance_saturation();
        test_unit_gain();
        test_floor_rounding();
        test_backpressure();
        test_random_phase(0, 0);
        test_random_phase(54, 0);
        test_random_phase(0, 54);
        test_random_phase(21, 21);

        wait_until_drained();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
